/* rtl/core/xor_checked_frame_receiver_macros.svh */
// Assertion macros for the frame receiver checkers.
`ifndef XOR_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define XOR_CHECKED_FRAME_RECEIVER_MACROS_SVH

// Check a property while out of reset.
`define XCFR_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every edge, reset included.
`define XCFR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/xcfr_pkg.sv */
`timescale 1ns / 1ps
package xcfr_pkg;

  localparam int unsigned MAX_FRAME = 64;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned IndexW = 2;

  typedef enum logic [1:0] {
    EV_STORED   = 2'd0,
    EV_ACCEPT   = 2'd1,
    EV_BAD_CHK  = 2'd2,
    EV_OVERFLOW = 2'd3
  } event_t;

  typedef enum logic [IndexW-1:0] {
    REG_HEAD  = 2'd0,
    REG_END   = 2'd1,
    REG_LIMIT = 2'd2
  } reg_idx_t;

  localparam logic [ByteW-1:0]  HeadReset  = 8'd170;
  localparam logic [ByteW-1:0]  EndReset   = 8'd85;
  localparam logic [CountW-1:0] LimitReset = 7'd32;

  typedef struct packed {
    logic [ByteW-1:0]  head_byte;
    logic [ByteW-1:0]  end_byte;
    logic [CountW-1:0] length_limit;
  } cfg_t;

endpackage

/* rtl/core/xor_checked_frame_receiver.sv */
`timescale 1ns / 1ps
// Byte-serial frame receiver with XOR check.
// Input channel (in_valid/in_ready/in_rx_byte): one received byte per request.
// Output channel (out_valid/out_ready/out_*): exactly one result per byte,
//   in byte order: event (stored, accepted, check failed, overflow cleared),
//   frame type and first data byte for accepted frames, and the byte count.
// Config port (cfg_we/cfg_index/cfg_wdata): head byte, end byte, length
//   limit; write only while no request is in flight.
// A byte taken passes through the input register, then through the collector
//   into the result register.
// Throughput: one byte per cycle while out_ready is high; the collector updates
//   count, running XOR and captured frame bytes for every byte taken.
// Reset (rst_n low, synchronous): registers return to head 170, end 85,
//   limit 32; the collector is emptied and both pipeline stages drop valid.
// Stall: when out_ready is low the result holds, the input register fills,
//   and in_ready falls once both stages are occupied.
module xor_checked_frame_receiver #(
  parameter int unsigned MAX_FRAME = xcfr_pkg::MAX_FRAME
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [xcfr_pkg::IndexW-1:0] cfg_index,
  input  logic [xcfr_pkg::ByteW-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [xcfr_pkg::ByteW-1:0]  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_event_res,
  output logic [xcfr_pkg::ByteW-1:0]  out_frame_type,
  output logic [xcfr_pkg::ByteW-1:0]  out_first_data,
  output logic [xcfr_pkg::CountW-1:0] out_frame_length
);

  xcfr_pkg::cfg_t             cfg;
  logic                       s1_valid;
  logic                       s1_ready;
  logic [xcfr_pkg::ByteW-1:0] s1_byte;

  xcfr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  xcfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .dn_valid   (s1_valid),
    .dn_ready   (s1_ready),
    .dn_byte    (s1_byte)
  );

  xcfr_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .up_valid         (s1_valid),
    .up_ready         (s1_ready),
    .up_byte          (s1_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_frame_type   (out_frame_type),
    .out_first_data   (out_first_data),
    .out_frame_length (out_frame_length)
  );

endmodule

/* rtl/core/xcfr_cfg.sv */
`timescale 1ns / 1ps
module xcfr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [xcfr_pkg::IndexW-1:0]   cfg_index,
  input  logic [xcfr_pkg::ByteW-1:0]    cfg_wdata,
  output xcfr_pkg::cfg_t                cfg
);

  xcfr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_byte    <= xcfr_pkg::HeadReset;
      cfg_r.end_byte     <= xcfr_pkg::EndReset;
      cfg_r.length_limit <= xcfr_pkg::LimitReset;
    end else if (cfg_we) begin
      case (cfg_index)
        xcfr_pkg::REG_HEAD:  cfg_r.head_byte    <= cfg_wdata;
        xcfr_pkg::REG_END:   cfg_r.end_byte     <= cfg_wdata;
        xcfr_pkg::REG_LIMIT: cfg_r.length_limit <= cfg_wdata[xcfr_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/xcfr_in_stage.sv */
`timescale 1ns / 1ps
module xcfr_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [xcfr_pkg::ByteW-1:0] in_rx_byte,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic [xcfr_pkg::ByteW-1:0] dn_byte
);

  logic                       valid_r;
  logic [xcfr_pkg::ByteW-1:0] byte_r;

  assign in_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign dn_valid = valid_r;
  assign dn_byte  = byte_r;

endmodule

/* rtl/core/xcfr_core.sv */
`timescale 1ns / 1ps
module xcfr_core #(
  parameter int unsigned MAX_FRAME = xcfr_pkg::MAX_FRAME
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  xcfr_pkg::cfg_t              cfg,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [xcfr_pkg::ByteW-1:0]  up_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_event_res,
  output logic [xcfr_pkg::ByteW-1:0]  out_frame_type,
  output logic [xcfr_pkg::ByteW-1:0]  out_first_data,
  output logic [xcfr_pkg::CountW-1:0] out_frame_length
);

  localparam int unsigned CmpW = 9;
  localparam logic [CmpW-1:0] MaxFrameC = CmpW'(MAX_FRAME);

  logic [xcfr_pkg::CountW-1:0] cnt_r, cnt_nxt;
  logic [xcfr_pkg::ByteW-1:0]  first_r, first_nxt;
  logic [xcfr_pkg::ByteW-1:0]  type_r, type_nxt;
  logic [xcfr_pkg::ByteW-1:0]  data_r, data_nxt;
  logic [xcfr_pkg::ByteW-1:0]  prev_r;
  logic [xcfr_pkg::ByteW-1:0]  xor_r, xor_nxt;

  logic                        out_valid_r;
  xcfr_pkg::event_t            ev_r, ev_nxt;
  logic [xcfr_pkg::ByteW-1:0]  ft_r, ft_nxt;
  logic [xcfr_pkg::ByteW-1:0]  fd_r, fd_nxt;
  logic [xcfr_pkg::CountW-1:0] len_r, len_nxt;

  logic                        take;
  logic [CmpW-1:0]             limit_ext;
  logic [CmpW-1:0]             eff_limit;
  logic                        close_frame;
  logic                        check_ok;

  assign up_ready = !out_valid_r || out_ready;
  assign take     = up_valid && up_ready;

  always_comb begin
    first_nxt = (cnt_r == '0) ? up_byte : first_r;
    xor_nxt   = (cnt_r == '0) ? '0 : (xor_r ^ prev_r);
    type_nxt  = (cnt_r == xcfr_pkg::CountW'(1)) ? up_byte : type_r;
    data_nxt  = (cnt_r == xcfr_pkg::CountW'(2)) ? up_byte : data_r;
    len_nxt   = cnt_r + xcfr_pkg::CountW'(1);

    limit_ext = CmpW'(cfg.length_limit);
    eff_limit = (limit_ext > MaxFrameC) ? MaxFrameC : limit_ext;

    close_frame = (up_byte == cfg.end_byte) && (first_nxt == cfg.head_byte);
    check_ok    = (len_nxt >= xcfr_pkg::CountW'(2)) &&
                  ((xor_r ^ cfg.end_byte) == prev_r);

    ev_nxt  = xcfr_pkg::EV_STORED;
    ft_nxt  = '0;
    fd_nxt  = '0;
    cnt_nxt = len_nxt;
    if (close_frame) begin
      cnt_nxt = '0;
      if (check_ok) begin
        ev_nxt = xcfr_pkg::EV_ACCEPT;
        ft_nxt = type_nxt;
        fd_nxt = (len_nxt >= xcfr_pkg::CountW'(3)) ? data_nxt : '0;
      end else begin
        ev_nxt = xcfr_pkg::EV_BAD_CHK;
      end
    end else if (CmpW'(len_nxt) >= eff_limit) begin
      ev_nxt  = xcfr_pkg::EV_OVERFLOW;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      first_r <= '0;
      type_r  <= '0;
      data_r  <= '0;
      prev_r  <= '0;
      xor_r   <= '0;
    end else if (take) begin
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      type_r  <= type_nxt;
      data_r  <= data_nxt;
      prev_r  <= up_byte;
      xor_r   <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev_r  <= ev_nxt;
      ft_r  <= ft_nxt;
      fd_r  <= fd_nxt;
      len_r <= len_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = ev_r;
  assign out_frame_type   = ft_r;
  assign out_first_data   = fd_r;
  assign out_frame_length = len_r;

endmodule

/* rtl/core/xcfr_checker.sv */
`timescale 1ns / 1ps
`include "xor_checked_frame_receiver_macros.svh"
module xcfr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_event_res,
  input logic [xcfr_pkg::ByteW-1:0]  out_frame_type,
  input logic [xcfr_pkg::ByteW-1:0]  out_first_data,
  input logic [xcfr_pkg::CountW-1:0] out_frame_length
);

  `XCFR_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid, "result valid after reset")
  `XCFR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `XCFR_ASSERT(a_len_nonzero, clk, rst_n, out_valid |-> out_frame_length != '0, "zero byte count in result")
  `XCFR_ASSERT(a_fields_idle, clk, rst_n, out_valid && out_event_res != xcfr_pkg::EV_ACCEPT |-> out_frame_type == '0 && out_first_data == '0, "frame fields set without accepted frame")
  `XCFR_ASSERT(a_no_result_from_nothing, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready) || $past(in_valid, 2), "result without request")

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_event_res    (out_event_res),
  .out_frame_type   (out_frame_type),
  .out_first_data   (out_first_data),
  .out_frame_length (out_frame_length)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import xcfr_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int PhaseCount   = 11;
  localparam int BytesPerPhase = 155;

  typedef struct packed {
    event_t            ev;
    logic [ByteW-1:0]  ftype;
    logic [ByteW-1:0]  fdata;
    logic [CountW-1:0] flen;
  } frame_res_t;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             typed;
    frame_res_t       res;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [IndexW-1:0] cfg_index;
  logic [ByteW-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [ByteW-1:0]  in_rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_event_res;
  logic [ByteW-1:0]  out_frame_type;
  logic [ByteW-1:0]  out_first_data;
  logic [CountW-1:0] out_frame_length;

  logic [ByteW-1:0]  cur_head;
  logic [ByteW-1:0]  cur_end;
  logic [CountW-1:0] cur_limit;
  logic [CountW-1:0] col_count;
  logic [ByteW-1:0]  col_first;
  logic [ByteW-1:0]  col_type;
  logic [ByteW-1:0]  col_data;
  logic [ByteW-1:0]  col_prev;
  logic [ByteW-1:0]  col_xor;

  frame_res_t pending_results[$];
  frame_res_t front;
  bit         quiet;
  int         errors;
  int         bytes_sent;
  int         cycle_count;
  int         n_stored;
  int         n_accept;
  int         n_bad;
  int         n_overflow;

  dir_row_t dir_rows [20] = '{
    '{8'hAA, 1'b1, '{EV_STORED, 8'h00, 8'h00, 7'd1}},
    '{8'h01, 1'b1, '{EV_STORED, 8'h00, 8'h00, 7'd2}},
    '{8'h02, 1'b1, '{EV_STORED, 8'h00, 8'h00, 7'd3}},
    '{8'hFC, 1'b1, '{EV_STORED, 8'h00, 8'h00, 7'd4}},
    '{8'h55, 1'b1, '{EV_ACCEPT, 8'h01, 8'h02, 7'd5}},
    '{8'hAA, 1'b1, '{EV_STORED, 8'h00, 8'h00, 7'd1}},
    '{8'hFF, 1'b1, '{EV_STORED, 8'h00, 8'h00, 7'd2}},
    '{8'h55, 1'b1, '{EV_ACCEPT, 8'hFF, 8'h55, 7'd3}},
    '{8'hAA, 1'b1, '{EV_STORED, 8'h00, 8'h00, 7'd1}},
    '{8'h55, 1'b1, '{EV_BAD_CHK, 8'h00, 8'h00, 7'd2}},
    '{8'hAA, 1'b1, '{EV_STORED, 8'h00, 8'h00, 7'd1}},
    '{8'h10, 1'b0, '0},
    '{8'h20, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h55, 1'b1, '{EV_BAD_CHK, 8'h00, 8'h00, 7'd5}},
    '{8'h55, 1'b1, '{EV_STORED, 8'h00, 8'h00, 7'd1}},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h55, 1'b0, '0}
  };

  xor_checked_frame_receiver u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_frame_type   (out_frame_type),
    .out_first_data   (out_first_data),
    .out_frame_length (out_frame_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic frame_res_t frame_step(input logic [ByteW-1:0] b);
    frame_res_t        res;
    logic [CountW-1:0] pos;
    logic [CountW-1:0] n;
    logic [ByteW-1:0]  chk_xor;
    logic [ByteW-1:0]  chk_byte;
    int                lim;
    pos      = col_count;
    chk_xor  = col_xor;
    chk_byte = col_prev;
    lim      = cur_limit;
    if (lim > MAX_FRAME) lim = MAX_FRAME;
    if (pos == 0) begin
      col_first = b;
      col_xor   = '0;
    end else begin
      col_xor = col_xor ^ col_prev;
    end
    col_prev = b;
    if (pos == 1) col_type = b;
    if (pos == 2) col_data = b;
    n         = pos + 7'd1;
    col_count = n;
    res       = '{EV_STORED, 8'h00, 8'h00, n};
    if (b == cur_end && col_first == cur_head) begin
      if (n >= 2 && (chk_xor ^ cur_end) == chk_byte) begin
        res.ev    = EV_ACCEPT;
        res.ftype = col_type;
        res.fdata = (n >= 3) ? col_data : 8'h00;
      end else begin
        res.ev = EV_BAD_CHK;
      end
      col_count = '0;
    end else if (n >= lim) begin
      res.ev    = EV_OVERFLOW;
      col_count = '0;
    end
    return res;
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic typed,
                           input frame_res_t typed_res);
    frame_res_t res;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    res = frame_step(b);
    if (typed) res = typed_res;
    pending_results.push_back(res);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [ByteW-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_HEAD:  cur_head  = val;
      REG_END:   cur_end   = val;
      REG_LIMIT: cur_limit = val[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_frame();
    logic [ByteW-1:0] fb[$];
    logic [ByteW-1:0] x;
    logic [ByteW-1:0] d;
    int               eff;
    int               kmax;
    int               k;
    while (col_count != 0)
      send_byte((col_first == cur_head) ? cur_end : 8'($urandom), 1'b0, '0);
    eff = (cur_limit > MAX_FRAME) ? MAX_FRAME : cur_limit;
    if (eff < 1) eff = 1;
    if (eff >= 5)
      kmax = ($urandom_range(0, 9) == 0 || eff - 4 < 6) ? eff - 4 : 6;
    else
      kmax = 0;
    fb.push_back(cur_head);
    if ($urandom_range(0, 7) == 0) begin
      fb.push_back(cur_head ^ cur_end);
    end else begin
      d = 8'($urandom);
      if (d == cur_end) d = ~d;
      fb.push_back(d);
      x = cur_head ^ d;
      k = $urandom_range(0, kmax);
      repeat (k) begin
        d = 8'($urandom);
        if (d == cur_end) d = d ^ 8'h01;
        fb.push_back(d);
        x = x ^ d;
      end
      x = x ^ cur_end;
      if ($urandom_range(0, 5) == 0) x = x ^ (8'h01 << $urandom_range(0, 7));
      fb.push_back(x);
    end
    if ($urandom_range(0, 9) != 0) fb.push_back(cur_end);
    foreach (fb[i]) send_byte(fb[i], 1'b0, '0);
  endtask

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          out_ready = 1'b0;
          @(negedge clk);
        end
      end
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      case (out_event_res)
        EV_STORED:   n_stored++;
        EV_ACCEPT:   n_accept++;
        EV_BAD_CHK:  n_bad++;
        default:     n_overflow++;
      endcase
      if (pending_results.size() == 0) begin
        $error("result with no pending request: event_res %0d", out_event_res);
        errors++;
      end else begin
        front = pending_results.pop_front();
        if (out_event_res !== front.ev) begin
          $error("event_res expected %0d actual %0d", front.ev, out_event_res);
          errors++;
        end
        if (out_frame_type !== front.ftype) begin
          $error("frame_type expected %0h actual %0h", front.ftype, out_frame_type);
          errors++;
        end
        if (out_first_data !== front.fdata) begin
          $error("first_data expected %0h actual %0h", front.fdata, out_first_data);
          errors++;
        end
        if (out_frame_length !== front.flen) begin
          $error("frame_length expected %0d actual %0d", front.flen, out_frame_length);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("xor_checked_frame_receiver verification failed");
      $finish;
    end
  end

  initial begin
    logic [ByteW-1:0]  h;
    logic [ByteW-1:0]  e;
    logic [CountW-1:0] lim;
    int                target;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    quiet      = 1'b0;
    cur_head   = HeadReset;
    cur_end    = EndReset;
    cur_limit  = LimitReset;
    col_count  = '0;
    col_first  = '0;
    col_type   = '0;
    col_data   = '0;
    col_prev   = '0;
    col_xor    = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        h   = 8'($urandom);
        e   = 8'($urandom);
        lim = 7'($urandom_range(3, 64));
        case (p)
          1: begin h = 8'h00; e = 8'hFF; lim = 7'd3;   end
          2: begin h = 8'hFF; e = 8'h00; lim = 7'd64;  end
          3: lim = 7'd127;
          4: begin e = h; lim = 7'd16; end
          5: lim = 7'd0;
          6: lim = 7'd1;
          7: lim = 7'd2;
          9: lim = 7'd8;
          default: ;
        endcase
        if (p != 4 && h == e) e = ~h;
        in_valid = 1'b0;
        wait_idle();
        write_reg(REG_HEAD, h);
        write_reg(REG_END, e);
        write_reg(REG_LIMIT, {1'b0, lim});
      end
      if (p == PhaseCount - 1) quiet = 1'b1;
      target = bytes_sent + BytesPerPhase;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0, '0);
        else
          send_frame();
      end
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d bytes over %0d register settings, %0d cycles", bytes_sent, PhaseCount,
             cycle_count);
    $display("stored %0d, accepted %0d, check failed %0d, overflow %0d", n_stored, n_accept,
             n_bad, n_overflow);
    if (errors == 0) begin
      $display("xor_checked_frame_receiver verification clean");
    end else begin
      $display("xor_checked_frame_receiver verification failed");
    end
    $finish;
  end

endmodule

/* xor_checked_frame_receiver.f */
+incdir+rtl/core
rtl/core/xcfr_pkg.sv
rtl/core/xcfr_cfg.sv
rtl/core/xcfr_in_stage.sv
rtl/core/xcfr_core.sv
rtl/core/xor_checked_frame_receiver.sv
rtl/core/xcfr_checker.sv
tb/tb_top.sv
